// ===== hdl/sle_pkg.sv =====
// shared types and constants for the serial line byte encoder
// used by sle_front, sle_fifo, sle_back and serial_line_byte_encoder
package sle_pkg;

	localparam int MAX_CHARS = 3;

	typedef enum logic [1:0] {
		MODE_SIX     = 2'd0,
		MODE_EIGHT   = 2'd1,
		MODE_NO_XON  = 2'd2,
		MODE_NO_CTRL = 2'd3
	} sle_mode_t;

	// one request for the back end: up to three characters
	typedef struct packed {
		logic [MAX_CHARS-1:0][7:0] chars;
		logic [1:0]                n;
		logic                      pend;
	} sle_entry_t;

	typedef struct packed {
		logic empty;
		logic full;
	} sle_fifo_stat_t;

endpackage

// ===== hdl/sle_front.sv =====
// front end: takes input bytes, keeps six-bit packing state and the mode
// register, and turns each byte into one request of up to three characters
// depends on sle_pkg
module sle_front import sle_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           mode_we,
	input  logic [1:0]     mode_wdata,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [7:0]     data_byte,
	input  logic           last_byte,
	input  logic           empty_packet,
	input  sle_fifo_stat_t fifo_stat,
	output logic           push,
	output sle_entry_t     push_entry
);

	localparam logic [7:0] ESC_CHAR  = 8'h40;
	localparam logic [7:0] CAN_CHAR  = 8'h18;
	localparam logic [7:0] XOFF_CHAR = 8'h13;
	localparam logic [7:0] XON_CHAR  = 8'h11;

	function automatic logic [7:0] alpha(input logic [5:0] idx);
		logic [7:0] c;
		if (idx < 6'd26)
			c = 8'h41 + {2'b00, idx};
		else if (idx < 6'd52)
			c = 8'h61 + {2'b00, idx} - 8'd26;
		else if (idx < 6'd62)
			c = 8'h30 + {2'b00, idx} - 8'd52;
		else if (idx == 6'd62)
			c = 8'h2e;
		else
			c = 8'h2f;
		return c;
	endfunction

	sle_mode_t  mode_q;
	logic [3:0] lbits_q;
	logic [2:0] lcnt_q;
	logic       mid_q;

	logic [3:0] lbits_d;
	logic [2:0] lcnt_d;
	logic       mid_d;
	logic [1:0] nchar;
	logic [3:0] rem_bits;
	logic [2:0] rem_cnt;
	logic [5:0] pad;
	logic       accept;
	sle_entry_t ent;

	assign in_ready = !fifo_stat.full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		ent      = '0;
		nchar    = 2'd0;
		lbits_d  = 4'd0;
		lcnt_d   = 3'd0;
		mid_d    = 1'b0;
		rem_bits = 4'd0;
		rem_cnt  = 3'd0;
		pad      = 6'd0;
		if (empty_packet) begin
			if (mode_q == MODE_SIX) begin
				ent.chars[0] = ESC_CHAR;
				nchar        = 2'd1;
			end
		end else if (mode_q == MODE_SIX) begin
			if (!mid_q) begin
				ent.chars[nchar] = ESC_CHAR;
				nchar            = nchar + 2'd1;
			end
			unique case (lcnt_q)
				3'd0: begin
					ent.chars[nchar] = alpha(data_byte[7:2]);
					nchar            = nchar + 2'd1;
					rem_bits         = {2'b00, data_byte[1:0]};
					rem_cnt          = 3'd2;
					pad              = {data_byte[1:0], 4'b0000};
				end
				3'd2: begin
					ent.chars[nchar] = alpha({lbits_q[1:0], data_byte[7:4]});
					nchar            = nchar + 2'd1;
					rem_bits         = data_byte[3:0];
					rem_cnt          = 3'd4;
					pad              = {data_byte[3:0], 2'b00};
				end
				default: begin
					ent.chars[nchar] = alpha({lbits_q, data_byte[7:6]});
					nchar            = nchar + 2'd1;
					ent.chars[nchar] = alpha(data_byte[5:0]);
					nchar            = nchar + 2'd1;
				end
			endcase
			if (last_byte) begin
				if (rem_cnt != 3'd0) begin
					ent.chars[nchar] = alpha(pad);
					nchar            = nchar + 2'd1;
				end
			end else begin
				lbits_d = rem_bits;
				lcnt_d  = rem_cnt;
				mid_d   = 1'b1;
			end
		end else begin
			mid_d = !last_byte;
			ent.chars[0] = ESC_CHAR;
			nchar        = 2'd2;
			if (data_byte == ESC_CHAR)
				ent.chars[1] = 8'h20;
			else if (data_byte == CAN_CHAR)
				ent.chars[1] = 8'h58;
			else if (mode_q == MODE_NO_XON && data_byte == XOFF_CHAR)
				ent.chars[1] = 8'h53;
			else if (mode_q == MODE_NO_XON && data_byte == XON_CHAR)
				ent.chars[1] = 8'h51;
			else if (mode_q == MODE_NO_CTRL && data_byte < 8'h20)
				ent.chars[1] = data_byte + ESC_CHAR;
			else begin
				ent.chars[0] = data_byte;
				nchar        = 2'd1;
			end
		end
		ent.n    = nchar;
		ent.pend = last_byte || empty_packet;
	end

	assign push       = accept && (nchar != 2'd0);
	assign push_entry = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_SIX;
			lbits_q <= 4'd0;
			lcnt_q  <= 3'd0;
			mid_q   <= 1'b0;
		end else begin
			if (mode_we)
				mode_q <= sle_mode_t'(mode_wdata);
			if (accept) begin
				lbits_q <= lbits_d;
				lcnt_q  <= lcnt_d;
				mid_q   <= mid_d;
			end
		end
	end

endmodule

// ===== hdl/sle_fifo.sv =====
// short request queue between the front and back ends
// depends on sle_pkg
module sle_fifo import sle_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sle_entry_t     push_entry,
	input  logic           pop,
	output sle_entry_t     head,
	output sle_fifo_stat_t stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	sle_entry_t       entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head       = entries_q[rd_ptr_q];
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == FULL_CNT);

	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT) else $error("queue count out of range");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0) else $error("pop from empty queue");
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not grow on push");

endmodule

// ===== hdl/sle_back.sv =====
// back end: drains requests from the queue and, while out_ready is high, sends one character per cycle
// depends on sle_pkg
module sle_back import sle_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  sle_entry_t     head,
	input  sle_fifo_stat_t fifo_stat,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     line_char,
	output logic           last_of_run,
	output logic           packet_end
);

	sle_entry_t entry_q;
	logic [1:0] idx_q;
	logic       busy_q;
	logic       last_char;

	assign last_char   = (idx_q == entry_q.n - 2'd1);
	assign pop         = !fifo_stat.empty && (!busy_q || (out_ready && last_char));
	assign out_valid   = busy_q;
	assign line_char   = entry_q.chars[idx_q];
	assign last_of_run = last_char;
	assign packet_end  = last_char && entry_q.pend;

	always_ff @(posedge clk) begin
		if (pop)
			entry_q <= head;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= 2'd0;
			busy_q <= 1'b0;
		end else if (pop) begin
			idx_q  <= 2'd0;
			busy_q <= 1'b1;
		end else if (busy_q && out_ready) begin
			if (last_char) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	a_entry_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> entry_q.n != 2'd0) else $error("request with no characters");
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q < entry_q.n) else $error("character index past request");

endmodule

// ===== hdl/serial_line_byte_encoder.sv =====
// serial line byte encoder, top level
// ties the front end, request queue and back end together; depends on sle_pkg
//
// s_* channel takes one packet byte per request: s_tdata is the byte, s_tlast
// marks the last byte of a packet, s_tuser marks an empty packet (no byte).
// m_* channel sends one line character per request: m_tlast marks the last
// character caused by one input request, m_tuser the last one of a packet.
// mode_we/mode_wdata write the 2-bit line mode (0 six-bit alphabet, 1 eight-bit,
// 2 eight-bit without xon/xoff, 3 eight-bit without controls); write only
// while idle.
// with the queue and back end idle, a taken input request is written into the
// queue, then loaded into the back end's entry register as m_tvalid rises.
// throughput: the back end sends one character per cycle while m_tready is high;
// a byte gives one to three characters (three at most, e.g. six-bit packet start
// with padding); the input takes a byte every cycle while the queue has room.
// reset clears the mode to six-bit, the packing state and the queue.
// when the receiver stalls, the current character holds and the queue of
// FIFO_DEPTH requests fills before s_tready drops.
module serial_line_byte_encoder import sle_pkg::*; #(
	parameter int FIFO_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       mode_we,
	input  logic [1:0] mode_wdata,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // data_byte
	input  logic       s_tlast,   // last_byte
	input  logic       s_tuser,   // empty_packet
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // line_char
	output logic       m_tlast,   // last_of_run
	output logic       m_tuser    // packet_end
);

	sle_fifo_stat_t fifo_stat;
	sle_entry_t     push_entry;
	sle_entry_t     head;
	logic           push;
	logic           pop;

	sle_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.mode_we      (mode_we),
		.mode_wdata   (mode_wdata),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.data_byte    (s_tdata),
		.last_byte    (s_tlast),
		.empty_packet (s_tuser),
		.fifo_stat    (fifo_stat),
		.push         (push),
		.push_entry   (push_entry)
	);

	sle_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.stat       (fifo_stat)
	);

	sle_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.fifo_stat   (fifo_stat),
		.pop         (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.line_char   (m_tdata),
		.last_of_run (m_tlast),
		.packet_end  (m_tuser)
	);

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for serial_line_byte_encoder: byte requests in all four line modes,
// each output character checked in order against a scoreboard that predicts the encoding
// depends on sle_pkg and the encoder rtl only
package sle_tb_pkg;
	import sle_pkg::*;

	localparam logic [7:0] AT_CHAR   = 8'h40;
	localparam logic [7:0] CAN_BYTE  = 8'h18;
	localparam logic [7:0] XOFF_BYTE = 8'h13;
	localparam logic [7:0] XON_BYTE  = 8'h11;

	typedef struct packed {
		logic [7:0] ch;
		logic       run_end;
		logic       pkt_end;
	} line_char_t;

	class sle_line_scoreboard;
		sle_mode_t  mode;
		logic [3:0] spare_bits;
		logic [2:0] spare_cnt;
		logic       in_packet;
		line_char_t chars_due[$];
		int         errors;
		int         requests;
		int         chars_seen;

		function new();
			mode = MODE_SIX;
			errors = 0;
			requests = 0;
			chars_seen = 0;
			clear_packing();
		endfunction

		function void clear_packing();
			spare_bits = '0;
			spare_cnt = '0;
			in_packet = 1'b0;
		endfunction

		function line_char_t plain(logic [7:0] ch);
			line_char_t c;
			c.ch = ch;
			c.run_end = 1'b0;
			c.pkt_end = 1'b0;
			return c;
		endfunction

		function logic [7:0] alpha_char(logic [5:0] g);
			if (g < 26)
				return "A" + g;
			if (g < 52)
				return "a" + (g - 26);
			if (g < 62)
				return "0" + (g - 52);
			return (g == 62) ? "." : "/";
		endfunction

		function void note_request(logic [7:0] b, logic last, logic empty);
			line_char_t  run[$];
			logic [11:0] acc;
			int          cnt;
			logic [7:0]  second;
			logic        esc;
			requests++;
			if (empty) begin
				// zero-length packet drops any unfinished bits
				clear_packing();
				if (mode == MODE_SIX) begin
					second = AT_CHAR;
					chars_due.push_back({second, 1'b1, 1'b1});
				end
				return;
			end
			if (mode == MODE_SIX) begin
				acc = {spare_bits, b};
				cnt = spare_cnt + 8;
				if (!in_packet)
					run.push_back(plain(AT_CHAR));
				while (cnt >= 6) begin
					run.push_back(plain(alpha_char(6'(acc >> (cnt - 6)))));
					cnt -= 6;
				end
				acc &= (12'd1 << cnt) - 12'd1;
				if (last) begin
					if (cnt > 0)
						run.push_back(plain(alpha_char(6'(acc << (6 - cnt)))));
					clear_packing();
				end else begin
					spare_bits = acc[3:0];
					spare_cnt = 3'(cnt);
					in_packet = 1'b1;
				end
			end else begin
				esc = 1'b1;
				second = b;
				if (b == AT_CHAR)
					second = " ";
				else if (b == CAN_BYTE)
					second = "X";
				else if (mode == MODE_NO_XON && b == XOFF_BYTE)
					second = "S";
				else if (mode == MODE_NO_XON && b == XON_BYTE)
					second = "Q";
				else if (mode == MODE_NO_CTRL && b < 8'h20)
					second = b + AT_CHAR;
				else
					esc = 1'b0;
				if (esc)
					run.push_back(plain(AT_CHAR));
				run.push_back(plain(second));
				clear_packing();
				in_packet = !last;
			end
			run[run.size() - 1].run_end = 1'b1;
			run[run.size() - 1].pkt_end = last;
			foreach (run[i])
				chars_due.push_back(run[i]);
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 20)
				$display("tb: mismatch at %0t: %s", $time, msg);
		endtask

		task check_char(logic [7:0] ch, logic run_end, logic pkt_end);
			line_char_t want;
			chars_seen++;
			if (chars_due.size() == 0) begin
				report($sformatf("character %02h with nothing expected", ch));
				return;
			end
			want = chars_due.pop_front();
			if (ch !== want.ch)
				report($sformatf("character %02h, expected %02h", ch, want.ch));
			if (run_end !== want.run_end)
				report($sformatf("m_tlast %b, expected %b", run_end, want.run_end));
			if (pkt_end !== want.pkt_end)
				report($sformatf("m_tuser %b, expected %b", pkt_end, want.pkt_end));
		endtask
	endclass
endpackage

module tb import sle_pkg::*, sle_tb_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PERIOD = 8;
	localparam int LIMIT_CYCLES = 200000;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       mode_we;
	logic [1:0] mode_wdata;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;   // data_byte
	logic       s_tlast;   // last_byte
	logic       s_tuser;   // empty_packet
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;   // line_char
	logic       m_tlast;   // last_of_run
	logic       m_tuser;   // packet_end

	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	bit hold_req = 1'b0;
	bit hold_seen = 1'b0;
	int hold_left = 0;
	int cycle_count = 0;

	sle_line_scoreboard sb = new();

	serial_line_byte_encoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode_we   (mode_we),
		.mode_wdata(mode_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	always #(PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("tb: timeout after %0d cycles", cycle_count);
			$display("tb: FAIL");
			$finish;
		end
	end

	// receiver: random stalls, plus a long hold-off when asked
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= 100;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_request(s_tdata, s_tlast, s_tuser);
			if (m_tvalid && m_tready)
				sb.check_char(m_tdata, m_tlast, m_tuser);
		end
	end

	task automatic send_item(input logic [7:0] b, input logic last, input logic empty);
		while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		s_tuser <= empty;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.chars_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_mode(input sle_mode_t m);
		mode_we <= 1'b1;
		mode_wdata <= m;
		@(posedge clk);
		mode_we <= 1'b0;
		sb.mode = m;
	endtask

	task automatic set_profile(input int p);
		case (p)
			0: begin
				tx_idle_pct = 0;
				rx_stall_pct = 0;
			end
			1: begin
				tx_idle_pct = 50;
				rx_stall_pct = 0;
			end
			2: begin
				tx_idle_pct = 0;
				rx_stall_pct = 50;
			end
			default: begin
				tx_idle_pct = 15;
				rx_stall_pct = 15;
			end
		endcase
	endtask

	function automatic logic [7:0] any_byte();
		if ($urandom_range(99) < 30) begin
			case ($urandom_range(7))
				0: return AT_CHAR;
				1: return CAN_BYTE;
				2: return XOFF_BYTE;
				3: return XON_BYTE;
				4: return 8'h00;
				5: return 8'h1f;
				6: return 8'h80;
				default: return 8'hff;
			endcase
		end
		return 8'($urandom);
	endfunction

	// mostly whole packets, some empty packets and some packets cut short
	task automatic random_packets(input int n_items);
		int  left;
		int  len;
		int  pick;
		logic cut;
		left = n_items;
		while (left > 0) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				send_item(8'($urandom), 1'($urandom), 1'b1);
				left--;
			end else begin
				len = (pick < 15) ? 8 + $urandom_range(4) : $urandom_range(1, 5);
				cut = (pick >= 92);
				for (int i = 0; i < len && left > 0; i++) begin
					send_item(any_byte(), (i == len - 1) && !cut, 1'b0);
					left--;
				end
			end
		end
	endtask

	task automatic directed();
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'hff, 1'b1, 1'b0);
		send_item(8'h4d, 1'b0, 1'b0);
		send_item(8'h61, 1'b0, 1'b0);
		send_item(8'h6e, 1'b1, 1'b0);
		send_item(8'hab, 1'b0, 1'b0);
		send_item(8'h5a, 1'b1, 1'b1);
		send_item(8'h12, 1'b0, 1'b0);
		send_item(8'h34, 1'b1, 1'b0);
		wait_drain();
		write_mode(MODE_EIGHT);
		send_item(AT_CHAR, 1'b0, 1'b0);
		send_item(CAN_BYTE, 1'b0, 1'b0);
		send_item(XOFF_BYTE, 1'b1, 1'b0);
		send_item(8'hff, 1'b0, 1'b1);
		// mode switch in the middle of a packet
		send_item(8'h55, 1'b0, 1'b0);
		wait_drain();
		write_mode(MODE_SIX);
		send_item(8'hc3, 1'b1, 1'b0);
		wait_drain();
		write_mode(MODE_NO_XON);
		send_item(XOFF_BYTE, 1'b0, 1'b0);
		send_item(XON_BYTE, 1'b0, 1'b0);
		send_item(AT_CHAR, 1'b0, 1'b0);
		send_item(CAN_BYTE, 1'b0, 1'b0);
		send_item(8'h12, 1'b1, 1'b0);
		wait_drain();
		write_mode(MODE_NO_CTRL);
		send_item(8'h00, 1'b0, 1'b0);
		send_item(8'h1f, 1'b0, 1'b0);
		send_item(8'h20, 1'b0, 1'b0);
		send_item(8'h80, 1'b0, 1'b0);
		send_item(8'hff, 1'b1, 1'b0);
		wait_drain();
	endtask

	initial begin
		sle_mode_t round_mode [8];
		round_mode = '{MODE_SIX, MODE_NO_CTRL, MODE_EIGHT, MODE_NO_XON,
			MODE_NO_XON, MODE_SIX, MODE_NO_CTRL, MODE_EIGHT};
		arst_n = 1'b0;
		mode_we = 1'b0;
		mode_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		directed();
		for (int r = 0; r < 8; r++) begin
			set_profile(r % 4);
			write_mode(round_mode[r]);
			random_packets(16);
			if (r == 2) begin
				hold_req = !hold_req;
				random_packets(12);
			end
			if (r == 5) begin
				wait_drain();
				random_packets(8);
			end
			wait_drain();
		end

		$display("tb: %0d requests sent, %0d line characters checked, %0d mismatches",
			sb.requests, sb.chars_seen, sb.errors);
		$display("tb: covered all four line modes, mid-packet mode switches, idle and stall mixes");
		if (sb.errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end
endmodule
